>>> src/necir_pkg.sv
// Package: shared constants, codes and types of the NEC infrared frame decoder.
package necir_pkg;

   localparam int FRAME_BITS = 32;
   localparam int WORD_W     = 32;
   localparam int CNT_W      = $clog2(FRAME_BITS + 1);
   localparam int IVL_W      = 15;
   localparam int TALLY_W    = 32;
   localparam int REG_COUNT  = 8;
   localparam int REG_IDX_W  = $clog2(REG_COUNT);
   localparam int CSR_ADDR_W = REG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_REPEAT_MIN = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_REPEAT_MAX = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_ONE_MIN    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_ONE_MAX    = 3'd7;

   localparam logic [IVL_W-1:0] CFG_RESET [REG_COUNT] = '{
      15'd12500, 15'd14500, 15'd10500, 15'd12000,
      15'd850,   15'd1450,  15'd1800,  15'd2800
   };

   localparam logic OP_EDGE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   localparam logic [1:0] EVT_FRAME_OK  = 2'd0;
   localparam logic [1:0] EVT_CMD_ERROR = 2'd1;
   localparam logic [1:0] EVT_REPEAT    = 2'd2;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [WORD_W-1:0]  raw_frame;
      logic [15:0]        address;
      logic [7:0]         command;
      logic               extended_address;
      logic [TALLY_W-1:0] repeats_seen;
   } result_type;

endpackage

>>> src/necir_ifs.sv
// Interfaces: request channel (edge/timeout items) and result channel of the decoder.
interface necir_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [14:0] interval_us;

   modport source (output valid, output operation, output interval_us, input ready);
   modport sink (input valid, input operation, input interval_us, output ready);
endinterface

interface necir_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [31:0] raw_frame;
   logic [15:0] address;
   logic [7:0]  command;
   logic        extended_address;
   logic [31:0] repeats_seen;

   modport source (output valid, output event_kind, output raw_frame, output address,
                   output command, output extended_address, output repeats_seen,
                   input ready);
   modport sink (input valid, input event_kind, input raw_frame, input address,
                 input command, input extended_address, input repeats_seen,
                 output ready);
endinterface

>>> src/nec_ir_frame_decoder.sv
// NEC IR frame decoder: takes one request per clock while req_bus.ready is high
// (falling-edge interval or timeout) and updates the decoder state in that same
// cycle. A frame or repeat result goes into the output register that drives
// rsp_bus, or into the one skid register while that holds an untaken result;
// req_bus.ready drops only when both hold results not yet taken. Window limits are
// set through the csr_ port and should only be written while the decoder is idle.
module nec_ir_frame_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   necir_req_if.sink                            req_bus,
   necir_rsp_if.source                          rsp_bus,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [necir_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [necir_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [necir_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import necir_pkg::*;

   logic [IVL_W-1:0]     cfg_ff [REG_COUNT];
   logic                 armed_ff, armed_in;
   logic                 receiving_ff, receiving_in;
   logic [CNT_W-1:0]     bits_ff, bits_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [TALLY_W-1:0]   tally_ff, tally_in;

   result_type           out_ff, out_in, skid_ff, skid_in, res;
   logic                 out_v_ff, out_v_in, skid_v_ff, skid_v_in;

   logic                 req_fire, rsp_pop, push;
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] csr_idx;
   logic                 in_lead, in_rep, in_zero, in_one;
   logic [WORD_W-1:0]    bit_mask, word_next;
   logic [CNT_W-1:0]     bits_next;
   logic [7:0]           b0, b1, b2, b3;
   logic                 ext;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_prdata = {{(CSR_DATA_W-IVL_W){1'b0}}, cfg_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            cfg_ff[i] <= CFG_RESET[i];
         end
      end else if (csr_wr) begin
         cfg_ff[csr_idx] <= csr_pwdata[IVL_W-1:0];
      end
   end

   // interval classification
   assign in_lead = (req_bus.interval_us >= cfg_ff[REG_LEADER_MIN])
                 && (req_bus.interval_us <= cfg_ff[REG_LEADER_MAX]);
   assign in_rep  = (req_bus.interval_us >= cfg_ff[REG_REPEAT_MIN])
                 && (req_bus.interval_us <= cfg_ff[REG_REPEAT_MAX]);
   assign in_zero = (req_bus.interval_us >= cfg_ff[REG_ZERO_MIN])
                 && (req_bus.interval_us <= cfg_ff[REG_ZERO_MAX]);
   assign in_one  = (req_bus.interval_us >= cfg_ff[REG_ONE_MIN])
                 && (req_bus.interval_us <= cfg_ff[REG_ONE_MAX]);

   always_comb begin
      bit_mask = '0;
      for (int i = 0; i < FRAME_BITS; i++) begin
         bit_mask[i] = (bits_ff == CNT_W'(i));
      end
   end

   assign word_next = in_zero ? word_ff : (word_ff | bit_mask);
   assign bits_next = bits_ff + CNT_W'(1);
   assign b0 = word_next[7:0];
   assign b1 = word_next[15:8];
   assign b2 = word_next[23:16];
   assign b3 = word_next[31:24];
   assign ext = (b0 ^ b1) != 8'hFF;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_pop  = rsp_bus.valid && rsp_bus.ready;

   // decoder state update
   always_comb begin
      armed_in     = armed_ff;
      receiving_in = receiving_ff;
      bits_in      = bits_ff;
      word_in      = word_ff;
      tally_in     = tally_ff;
      push         = 1'b0;
      res          = '0;
      if (req_fire) begin
         if (req_bus.operation == OP_TIMEOUT) begin
            armed_in     = 1'b0;
            receiving_in = 1'b0;
            bits_in      = '0;
            word_in      = '0;
         end else if (!armed_ff) begin
            armed_in = 1'b1;
         end else if (in_lead) begin
            receiving_in = 1'b1;
            bits_in      = '0;
            word_in      = '0;
            tally_in     = '0;
         end else if (in_rep) begin
            tally_in         = tally_ff + TALLY_W'(1);
            receiving_in     = 1'b0;
            bits_in          = '0;
            word_in          = '0;
            push             = 1'b1;
            res.event_kind   = EVT_REPEAT;
            res.repeats_seen = tally_ff + TALLY_W'(1);
         end else if (receiving_ff) begin
            if (in_zero || in_one) begin
               if (bits_next == CNT_W'(FRAME_BITS)) begin
                  push                 = 1'b1;
                  res.event_kind       = ((b2 ^ b3) == 8'hFF) ? EVT_FRAME_OK : EVT_CMD_ERROR;
                  res.raw_frame        = word_next;
                  res.address          = ext ? {b1, b0} : {8'h00, b0};
                  res.command          = b2;
                  res.extended_address = ext;
                  res.repeats_seen     = tally_ff;
                  receiving_in         = 1'b0;
                  bits_in              = '0;
                  word_in              = '0;
               end else begin
                  bits_in = bits_next;
                  word_in = word_next;
               end
            end else begin
               receiving_in = 1'b0;
               bits_in      = '0;
               word_in      = '0;
            end
         end
      end
   end

   // result register with skid stage
   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (!out_v_ff || rsp_pop) begin
         out_in   = skid_v_ff ? skid_ff : res;
         out_v_in = skid_v_ff || push;
         if (skid_v_ff) begin
            skid_in   = res;
            skid_v_in = push;
         end
      end else if (push) begin
         skid_in   = res;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         receiving_ff <= 1'b0;
         bits_ff      <= '0;
         word_ff      <= '0;
         tally_ff     <= '0;
         out_v_ff     <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else begin
         armed_ff     <= armed_in;
         receiving_ff <= receiving_in;
         bits_ff      <= bits_in;
         word_ff      <= word_in;
         tally_ff     <= tally_in;
         out_v_ff     <= out_v_in;
         skid_v_ff    <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_bus.ready            = !skid_v_ff;
   assign rsp_bus.valid            = out_v_ff;
   assign rsp_bus.event_kind       = out_ff.event_kind;
   assign rsp_bus.raw_frame        = out_ff.raw_frame;
   assign rsp_bus.address          = out_ff.address;
   assign rsp_bus.command          = out_ff.command;
   assign rsp_bus.extended_address = out_ff.extended_address;
   assign rsp_bus.repeats_seen     = out_ff.repeats_seen;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a result while output register is empty");

   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_ff < CNT_W'(FRAME_BITS))
      else $error("bit count reached frame length without emitting");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !receiving_ff |-> (bits_ff == '0) && (word_ff == '0))
      else $error("frame state left over while not receiving");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp_pop |=> $stable(skid_ff))
      else $error("skid result overwritten while stalled");
`endif

endmodule

>>> bench/nec_ir_frame_decoder_tb.sv
// Self-checking testbench for the NEC infrared frame decoder.
module nec_ir_frame_decoder_tb;
   import necir_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASE_ITEMS    = 400;
   localparam int NUM_SETS       = 5;
   localparam logic [IVL_W-1:0] IVL_TOP = 15'd19999;

   // leader, repeat, zero, one windows as min/max pairs; the last set restores reset values
   localparam logic [IVL_W-1:0] WINDOW_SETS [NUM_SETS][REG_COUNT] = '{
      '{15'd19000, 15'd19999, 15'd15000, 15'd18999, 15'd0,    15'd0,    15'd1,    15'd400},
      '{15'd1000,  15'd3000,  15'd2000,  15'd4000,  15'd500,  15'd2500, 15'd2000, 15'd6000},
      '{15'd5000,  15'd9000,  15'd19999, 15'd0,     15'd0,    15'd2000, 15'd2001, 15'd4999},
      '{15'd0,     15'd100,   15'd16384, 15'd19999, 15'd200,  15'd1000, 15'd1001, 15'd16383},
      '{15'd12500, 15'd14500, 15'd10500, 15'd12000, 15'd850,  15'd1450, 15'd1800, 15'd2800}
   };
   localparam int SEND_IDLE_PCT  [4] = '{0, 54, 0, 33};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 54, 33};

   typedef enum {SYM_LEADER, SYM_REPEAT, SYM_ZERO, SYM_ONE, SYM_OTHER} symbol_type;

   typedef struct packed {
      logic             operation;
      logic [IVL_W-1:0] interval_us;
   } ir_event_type;

   logic clock;
   logic reset;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   necir_req_if req_bus ();
   necir_rsp_if rsp_bus ();

   nec_ir_frame_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ir_event_type ir_events_to_send [$];
   result_type   expected_decodes [$];

   // decoder copy
   logic [IVL_W-1:0]   win_limit [REG_COUNT] = CFG_RESET;
   logic               armed        = 1'b0;
   logic               receiving    = 1'b0;
   logic [CNT_W-1:0]   bit_count    = '0;
   logic [WORD_W-1:0]  shift_word   = '0;
   logic [TALLY_W-1:0] repeat_tally = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned events_taken   = 0;
   int unsigned decodes_seen   = 0;
   int unsigned frames_ok      = 0;
   int unsigned cmd_errors     = 0;
   int unsigned repeats_rx     = 0;
   int unsigned mismatches     = 0;
   int unsigned quiet_cycles   = 0;

   always #6 clock = ~clock;

   function automatic symbol_type classify(input logic [IVL_W-1:0] iv);
      if (iv >= win_limit[REG_LEADER_MIN] && iv <= win_limit[REG_LEADER_MAX]) return SYM_LEADER;
      if (iv >= win_limit[REG_REPEAT_MIN] && iv <= win_limit[REG_REPEAT_MAX]) return SYM_REPEAT;
      if (iv >= win_limit[REG_ZERO_MIN] && iv <= win_limit[REG_ZERO_MAX]) return SYM_ZERO;
      if (iv >= win_limit[REG_ONE_MIN] && iv <= win_limit[REG_ONE_MAX]) return SYM_ONE;
      return SYM_OTHER;
   endfunction

   function automatic void clear_frame();
      receiving  = 1'b0;
      bit_count  = '0;
      shift_word = '0;
   endfunction

   function automatic void decode_ir_event(input logic op, input logic [IVL_W-1:0] iv);
      result_type res;
      symbol_type sym;
      logic [7:0] b0, b1, b2, b3;
      res = '0;
      sym = classify(iv);
      if (op == OP_TIMEOUT) begin
         armed = 1'b0;
         clear_frame();
      end else if (!armed) begin
         armed = 1'b1;
      end else if (sym == SYM_LEADER) begin
         clear_frame();
         receiving    = 1'b1;
         repeat_tally = '0;
      end else if (sym == SYM_REPEAT) begin
         repeat_tally     = repeat_tally + 1'b1;
         clear_frame();
         res.event_kind   = EVT_REPEAT;
         res.repeats_seen = repeat_tally;
         expected_decodes.push_back(res);
      end else if (receiving) begin
         if (sym == SYM_ZERO || sym == SYM_ONE) begin
            shift_word[bit_count[4:0]] = (sym == SYM_ONE);
            bit_count = bit_count + 1'b1;
            if (bit_count == FRAME_BITS) begin
               b0 = shift_word[7:0];
               b1 = shift_word[15:8];
               b2 = shift_word[23:16];
               b3 = shift_word[31:24];
               res.event_kind       = ((b2 ^ b3) == 8'hFF) ? EVT_FRAME_OK : EVT_CMD_ERROR;
               res.extended_address = ((b0 ^ b1) != 8'hFF);
               res.address          = res.extended_address ? {b1, b0} : {8'h00, b0};
               res.command          = b2;
               res.raw_frame        = shift_word;
               res.repeats_seen     = repeat_tally;
               expected_decodes.push_back(res);
               clear_frame();
            end
         end else begin
            clear_frame();
         end
      end
   endfunction

   // driver
   always @(posedge clock) begin
      logic taken;
      taken = req_bus.valid && req_bus.ready;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (taken) begin
            decode_ir_event(req_bus.operation, req_bus.interval_us);
            void'(ir_events_to_send.pop_front());
            events_taken++;
         end
         if (!req_bus.valid || taken) begin
            if (ir_events_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid       <= 1'b1;
               req_bus.operation   <= ir_events_to_send[0].operation;
               req_bus.interval_us <= ir_events_to_send[0].interval_us;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            decodes_seen++;
            if (expected_decodes.size() == 0) begin
               $display("%0t: unexpected result, expected none actual kind %0d frame 0x%0h",
                        $time, rsp_bus.event_kind, rsp_bus.raw_frame);
               mismatches++;
            end else begin
               want = expected_decodes.pop_front();
               check_field("event_kind", 32'(want.event_kind), 32'(rsp_bus.event_kind));
               check_field("raw_frame", want.raw_frame, rsp_bus.raw_frame);
               check_field("address", 32'(want.address), 32'(rsp_bus.address));
               check_field("command", 32'(want.command), 32'(rsp_bus.command));
               check_field("extended_address", 32'(want.extended_address),
                           32'(rsp_bus.extended_address));
               check_field("repeats_seen", want.repeats_seen, rsp_bus.repeats_seen);
               case (want.event_kind)
                  EVT_FRAME_OK:  frames_ok++;
                  EVT_CMD_ERROR: cmd_errors++;
                  default:       repeats_rx++;
               endcase
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d results outstanding",
                  quiet_cycles, expected_decodes.size());
         $display("nec_ir_frame_decoder regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_window(input logic [REG_IDX_W-1:0] idx, input logic [IVL_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      win_limit[idx] = value;
   endtask

   task automatic wait_idle();
      while (ir_events_to_send.size() != 0 || expected_decodes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void push_event(input logic op, input logic [IVL_W-1:0] iv);
      ir_events_to_send.push_back('{operation: op, interval_us: iv});
   endfunction

   function automatic logic [IVL_W-1:0] pick_interval(input symbol_type sym);
      logic [IVL_W-1:0] lo, hi, v;
      case (sym)
         SYM_LEADER: begin lo = win_limit[REG_LEADER_MIN]; hi = win_limit[REG_LEADER_MAX]; end
         SYM_REPEAT: begin lo = win_limit[REG_REPEAT_MIN]; hi = win_limit[REG_REPEAT_MAX]; end
         SYM_ZERO:   begin lo = win_limit[REG_ZERO_MIN];   hi = win_limit[REG_ZERO_MAX];   end
         SYM_ONE:    begin lo = win_limit[REG_ONE_MIN];    hi = win_limit[REG_ONE_MAX];    end
         default:    begin lo = '0;                        hi = IVL_TOP;                   end
      endcase
      if (lo > hi) begin
         lo = '0;
         hi = IVL_TOP;
      end
      for (int t = 0; t < 64; t++) begin
         v = IVL_W'($urandom_range(hi, lo));
         if (classify(v) == sym) return v;
      end
      return IVL_W'($urandom_range(IVL_TOP, 0));
   endfunction

   // timeout always followed by an arming edge so that later frames get through
   function automatic void push_timeout();
      push_event(OP_TIMEOUT, IVL_W'($urandom_range(IVL_TOP, 0)));
      push_event(OP_EDGE, IVL_W'($urandom_range(IVL_TOP, 0)));
   endfunction

   function automatic int push_traffic();
      logic [WORD_W-1:0] word;
      int                kind, break_at, start;
      start = ir_events_to_send.size();
      kind  = $urandom_range(99);
      if (kind < 60) begin
         word = $urandom();
         if ($urandom_range(1)) word[15:8] = ~word[7:0];
         if ($urandom_range(3) != 0) word[31:24] = ~word[23:16];
         break_at = ($urandom_range(9) == 0) ? $urandom_range(31) : FRAME_BITS;
         push_event(OP_EDGE, pick_interval(SYM_LEADER));
         for (int i = 0; i < FRAME_BITS; i++) begin
            if (i == break_at) begin
               if ($urandom_range(1)) push_timeout();
               else push_event(OP_EDGE, pick_interval(SYM_OTHER));
            end
            push_event(OP_EDGE, pick_interval(word[i] ? SYM_ONE : SYM_ZERO));
         end
         repeat ($urandom_range(3)) push_event(OP_EDGE, pick_interval(SYM_REPEAT));
      end else if (kind < 75) begin
         repeat ($urandom_range(4, 1)) push_event(OP_EDGE, pick_interval(SYM_REPEAT));
      end else if (kind < 85) begin
         push_timeout();
      end else begin
         repeat ($urandom_range(6, 1)) begin
            if ($urandom_range(4) == 0) push_timeout();
            else push_event(OP_EDGE, IVL_W'($urandom_range(IVL_TOP, 0)));
         end
      end
      return ir_events_to_send.size() - start;
   endfunction

   initial begin
      int phase_count;
      clock               = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_EDGE;
      req_bus.interval_us = '0;
      rsp_bus.ready       = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed pass under reset windows
      push_event(OP_TIMEOUT, IVL_TOP);
      push_event(OP_EDGE, 15'd0);
      push_event(OP_EDGE, IVL_TOP);
      push_event(OP_EDGE, 15'd10500);
      push_event(OP_EDGE, 15'd12000);
      push_event(OP_EDGE, 15'd12500);
      push_event(OP_EDGE, 15'd850);
      push_event(OP_EDGE, 15'd2800);
      push_event(OP_EDGE, 15'd1450);
      push_event(OP_EDGE, 15'd1800);
      push_event(OP_EDGE, 15'd12499);
      push_event(OP_EDGE, 15'd1000);
      push_event(OP_EDGE, 15'd14500);
      push_event(OP_EDGE, 15'd1000);
      push_event(OP_TIMEOUT, 15'd16384);
      push_event(OP_EDGE, 15'd11000);
      push_event(OP_EDGE, 15'd11000);
      push_event(OP_EDGE, 15'd14501);
      push_event(OP_EDGE, 15'd10499);
      push_event(OP_EDGE, 15'd2801);
      push_event(OP_EDGE, 15'd849);
      push_event(OP_EDGE, 15'd1451);

      for (int s = 0; s < NUM_SETS; s++) begin
         wait_idle();
         for (int r = 0; r < REG_COUNT; r++)
            write_window(REG_IDX_W'(r), WINDOW_SETS[s][r]);
         @(negedge clock);
         send_idle_pct  = SEND_IDLE_PCT[s % 4];
         recv_stall_pct = RECV_STALL_PCT[s % 4];
         phase_count = 0;
         while (phase_count < PHASE_ITEMS)
            phase_count += push_traffic();
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("covered %0d requests and %0d results: %0d good frames, %0d command errors,",
               events_taken, decodes_seen, frames_ok, cmd_errors);
      $display("%0d repeats; reset windows plus %0d programmed window sets, idle/stall mixes rotated",
               repeats_rx, NUM_SETS);
      if (mismatches == 0) begin
         $display("nec_ir_frame_decoder regression: pass");
      end else begin
         $display("nec_ir_frame_decoder regression: fail");
      end
      $finish;
   end

endmodule
